@@ sv/cag_pkg.sv @@
// ----------------------------------------------------------------------------
// cag_pkg
// Shared codes and helpers for the add-group execute block: item kinds,
// register select codes, opcode values and the flag helpers.
// ----------------------------------------------------------------------------
package cag_pkg;

  // item kinds
  localparam logic [1:0] KIND_EXEC     = 2'd0;
  localparam logic [1:0] KIND_WR_REG   = 2'd1;
  localparam logic [1:0] KIND_WR_SP    = 2'd2;
  localparam logic [1:0] KIND_WR_PC    = 2'd3;

  // register select / operand field codes
  localparam logic [2:0] SEL_B     = 3'd0;
  localparam logic [2:0] SEL_C     = 3'd1;
  localparam logic [2:0] SEL_D     = 3'd2;
  localparam logic [2:0] SEL_E     = 3'd3;
  localparam logic [2:0] SEL_H     = 3'd4;
  localparam logic [2:0] SEL_L     = 3'd5;
  localparam logic [2:0] SEL_FLAGS = 3'd6;
  localparam logic [2:0] SEL_A     = 3'd7;

  // opcodes and opcode groups
  localparam logic [4:0] OPG_ADD = 5'b10000;  // 0x80..0x87
  localparam logic [4:0] OPG_ADC = 5'b10001;  // 0x88..0x8f
  localparam logic [7:0] OP_ADI  = 8'hC6;
  localparam logic [7:0] OP_ACI  = 8'hCE;
  localparam logic [7:0] OP_DAA  = 8'h27;
  localparam logic [3:0] OPL_DAD = 4'h9;      // 0x09 0x19 0x29 0x39

  // register pair codes of dad
  localparam logic [1:0] RP_BC = 2'd0;
  localparam logic [1:0] RP_DE = 2'd1;
  localparam logic [1:0] RP_HL = 2'd2;
  localparam logic [1:0] RP_SP = 2'd3;

  // flags byte bit positions
  localparam int FB_S  = 7;
  localparam int FB_Z  = 6;
  localparam int FB_AC = 4;
  localparam int FB_P  = 2;
  localparam int FB_CY = 0;

  localparam logic [3:0] BCD_MAX_DIGIT = 4'd9;
  localparam logic [3:0] DAA_LO_CORR   = 4'h6;

  typedef struct packed {
    logic z;
    logic s;
    logic p;
    logic cy;
    logic ac;
  } flags_t;

  // set when the byte has an even number of ones
  function automatic logic even_parity(input logic [7:0] v);
    return ~(^v);
  endfunction

endpackage

@@ sv/cpu_add_group_execute.sv @@
// ----------------------------------------------------------------------------
// cpu_add_group_execute
// Executes the add group of an 8-bit processor (add, adc, adi, aci, dad, daa)
// on its own register file, stack pointer, program counter and flags.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_stall, in_kind .. in_write_value | item in
//  out     | out_valid, out_stall, out_acc_out .. out_not_handled | result out
//
//  one item per clock unless in_stall holds the input: a transfer on in updates the
//  architectural state at that edge and the result shows on out from the next cycle on
//  the result fields are the state registers themselves; one short 8/16 bit
//  add with flag logic sits between them and their next value
//  in_stall follows out_stall while a result is still waiting, so the state
//  and the shown result hold together during a stall
//  rst_n (synchronous, low) clears all registers, flags, sp and pc
//
module cpu_add_group_execute (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_opcode,
  input  logic [7:0]  in_mem_byte,
  input  logic [2:0]  in_reg_select,
  input  logic [15:0] in_write_value,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_acc_out,
  output logic [7:0]  out_h_out,
  output logic [7:0]  out_l_out,
  output logic        out_zero_flag,
  output logic        out_sign_flag,
  output logic        out_parity_flag,
  output logic        out_carry_flag,
  output logic        out_aux_carry_flag,
  output logic [15:0] out_pc_out,
  output logic        out_not_handled
);

  // architectural state
  logic [7:0]       b_r, c_r, d_r, e_r, h_r, l_r, a_r;
  logic [7:0]       b_nxt, c_nxt, d_nxt, e_nxt, h_nxt, l_nxt, a_nxt;
  logic [15:0]      sp_r, sp_nxt;
  logic [15:0]      pc_r, pc_nxt;
  cag_pkg::flags_t  flg_r, flg_nxt;
  logic             nh_r, nh_nxt;
  logic             out_valid_r;

  logic in_xfer;

  // decode
  logic is_add, is_adc, is_adi, is_aci, is_dad, is_daa, is_acc_add;
  logic use_carry;

  // 8-bit add datapath
  logic [7:0]  operand;
  logic [7:0]  add_val;
  logic        add_cin;
  logic [8:0]  add_sum;
  logic [4:0]  add_nib;

  // dad datapath
  logic [15:0] pair;
  logic [16:0] dad_sum;

  // daa datapath
  logic [3:0]  daa_lo, daa_hi;
  logic        daa_fix_lo, daa_fix_hi;
  logic [7:0]  daa_corr;
  logic [4:0]  daa_nib;
  logic [7:0]  daa_res;

  // a transfer is taken whenever the shown result is gone or being taken
  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  // opcode decode
  always_comb begin
    is_add     = (in_opcode[7:3] == cag_pkg::OPG_ADD);
    is_adc     = (in_opcode[7:3] == cag_pkg::OPG_ADC);
    is_adi     = (in_opcode == cag_pkg::OP_ADI);
    is_aci     = (in_opcode == cag_pkg::OP_ACI);
    is_dad     = (in_opcode[7:6] == 2'b00) && (in_opcode[3:0] == cag_pkg::OPL_DAD);
    is_daa     = (in_opcode == cag_pkg::OP_DAA);
    is_acc_add = is_add | is_adc | is_adi | is_aci;
    use_carry  = is_adc | is_aci;
  end

  // operand pick for the register / memory forms
  always_comb begin
    unique case (in_opcode[2:0])
      cag_pkg::SEL_B:     operand = b_r;
      cag_pkg::SEL_C:     operand = c_r;
      cag_pkg::SEL_D:     operand = d_r;
      cag_pkg::SEL_E:     operand = e_r;
      cag_pkg::SEL_H:     operand = h_r;
      cag_pkg::SEL_L:     operand = l_r;
      cag_pkg::SEL_FLAGS: operand = in_mem_byte;  // M form
      default:            operand = a_r;
    endcase
  end

  // accumulator add: carry in is part of one 9-bit sum
  always_comb begin
    add_val = (is_adi | is_aci) ? in_mem_byte : operand;
    add_cin = use_carry & flg_r.cy;
    add_sum = {1'b0, a_r} + {1'b0, add_val} + {8'd0, add_cin};
    add_nib = {1'b0, a_r[3:0]} + {1'b0, add_val[3:0]} + {4'd0, add_cin};
  end

  // hl add with a register pair
  always_comb begin
    unique case (in_opcode[5:4])
      cag_pkg::RP_BC: pair = {b_r, c_r};
      cag_pkg::RP_DE: pair = {d_r, e_r};
      cag_pkg::RP_HL: pair = {h_r, l_r};
      default:        pair = sp_r;
    endcase
    dad_sum = {1'b0, h_r, l_r} + {1'b0, pair};
  end

  // decimal adjust, correction from the original accumulator
  always_comb begin
    daa_lo     = a_r[3:0];
    daa_hi     = a_r[7:4];
    daa_fix_lo = flg_r.ac | (daa_lo > cag_pkg::BCD_MAX_DIGIT);
    daa_fix_hi = flg_r.cy | (daa_hi > cag_pkg::BCD_MAX_DIGIT) |
                 ((daa_hi >= cag_pkg::BCD_MAX_DIGIT) & (daa_lo > cag_pkg::BCD_MAX_DIGIT));
    daa_corr   = {(daa_fix_hi ? cag_pkg::DAA_LO_CORR : 4'h0),
                  (daa_fix_lo ? cag_pkg::DAA_LO_CORR : 4'h0)};
    daa_nib    = {1'b0, daa_lo} + {1'b0, daa_corr[3:0]};
    daa_res    = a_r + daa_corr;
  end

  // next state
  always_comb begin
    b_nxt   = b_r;
    c_nxt   = c_r;
    d_nxt   = d_r;
    e_nxt   = e_r;
    h_nxt   = h_r;
    l_nxt   = l_r;
    a_nxt   = a_r;
    sp_nxt  = sp_r;
    pc_nxt  = pc_r;
    flg_nxt = flg_r;
    nh_nxt  = 1'b0;
    unique case (in_kind)
      cag_pkg::KIND_WR_REG: begin
        unique case (in_reg_select)
          cag_pkg::SEL_B:     b_nxt = in_write_value[7:0];
          cag_pkg::SEL_C:     c_nxt = in_write_value[7:0];
          cag_pkg::SEL_D:     d_nxt = in_write_value[7:0];
          cag_pkg::SEL_E:     e_nxt = in_write_value[7:0];
          cag_pkg::SEL_H:     h_nxt = in_write_value[7:0];
          cag_pkg::SEL_L:     l_nxt = in_write_value[7:0];
          cag_pkg::SEL_FLAGS: begin
            flg_nxt.s  = in_write_value[cag_pkg::FB_S];
            flg_nxt.z  = in_write_value[cag_pkg::FB_Z];
            flg_nxt.ac = in_write_value[cag_pkg::FB_AC];
            flg_nxt.p  = in_write_value[cag_pkg::FB_P];
            flg_nxt.cy = in_write_value[cag_pkg::FB_CY];
          end
          default:            a_nxt = in_write_value[7:0];
        endcase
      end
      cag_pkg::KIND_WR_SP: sp_nxt = in_write_value;
      cag_pkg::KIND_WR_PC: pc_nxt = in_write_value;
      default: begin
        priority if (is_acc_add) begin
          a_nxt      = add_sum[7:0];
          flg_nxt.cy = add_sum[8];
          flg_nxt.ac = add_nib[4];
          flg_nxt.z  = (add_sum[7:0] == 8'd0);
          flg_nxt.s  = add_sum[7];
          flg_nxt.p  = cag_pkg::even_parity(add_sum[7:0]);
          // immediate forms are two bytes long
          pc_nxt     = pc_r + ((is_adi | is_aci) ? 16'd2 : 16'd1);
        end else if (is_dad) begin
          h_nxt      = dad_sum[15:8];
          l_nxt      = dad_sum[7:0];
          flg_nxt.cy = dad_sum[16];
          pc_nxt     = pc_r + 16'd1;
        end else if (is_daa) begin
          a_nxt      = daa_res;
          flg_nxt.cy = flg_r.cy | daa_fix_hi;
          flg_nxt.ac = daa_nib[4];
          flg_nxt.z  = (daa_res == 8'd0);
          flg_nxt.s  = daa_res[7];
          flg_nxt.p  = cag_pkg::even_parity(daa_res);
          pc_nxt     = pc_r + 16'd1;
        end else begin
          // not in the group: state untouched
          nh_nxt = 1'b1;
        end
      end
    endcase
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r         <= 8'd0;
      c_r         <= 8'd0;
      d_r         <= 8'd0;
      e_r         <= 8'd0;
      h_r         <= 8'd0;
      l_r         <= 8'd0;
      a_r         <= 8'd0;
      sp_r        <= 16'd0;
      pc_r        <= 16'd0;
      flg_r       <= '0;
      nh_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        b_r   <= b_nxt;
        c_r   <= c_nxt;
        d_r   <= d_nxt;
        e_r   <= e_nxt;
        h_r   <= h_nxt;
        l_r   <= l_nxt;
        a_r   <= a_nxt;
        sp_r  <= sp_nxt;
        pc_r  <= pc_nxt;
        flg_r <= flg_nxt;
        nh_r  <= nh_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_acc_out        = a_r;
  assign out_h_out          = h_r;
  assign out_l_out          = l_r;
  assign out_zero_flag      = flg_r.z;
  assign out_sign_flag      = flg_r.s;
  assign out_parity_flag    = flg_r.p;
  assign out_carry_flag     = flg_r.cy;
  assign out_aux_carry_flag = flg_r.ac;
  assign out_pc_out         = pc_r;
  assign out_not_handled    = nh_r;

  // every accepted transfer shows a result in the next cycle
  a_xfer_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("accepted transfer produced no result");

  // an opcode outside the group leaves the state alone
  a_nh_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && nh_nxt |=> pc_r == $past(pc_r) && a_r == $past(a_r) &&
                          h_r == $past(h_r) && l_r == $past(l_r) &&
                          flg_r == $past(flg_r))
    else $error("unhandled opcode changed state");

  // immediate adds step the pc by two
  a_imm_pc: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_kind == cag_pkg::KIND_EXEC && (is_adi || is_aci) |=>
      pc_r == $past(pc_r) + 16'd2)
    else $error("immediate add pc step wrong");

  // a stack pointer write touches nothing shown on the result
  a_sp_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_kind == cag_pkg::KIND_WR_SP |=>
      pc_r == $past(pc_r) && a_r == $past(a_r) && flg_r == $past(flg_r) && !nh_r)
    else $error("sp write disturbed other state");

  // no state change while a result is held
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(a_r) && $stable(pc_r) && $stable(flg_r))
    else $error("state moved during a stall");

endmodule

@@ tb/cpu_add_group_execute_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpu_add_group_execute_tb
// Self-checking bench for the add-group execute block. A scoreboard keeps its
// own copy of the registers, flags, sp and pc, predicts the result of every
// input transfer and checks each result transfer field by field. Directed
// corner cases come first, then about 1200 random items with bursty input and
// a patterned, sometimes long, output stall.
// ----------------------------------------------------------------------------
module cpu_add_group_execute_tb;

  localparam int ITEM_TARGET = 1200;
  localparam int IDLE_LIMIT  = 2000;  // cycles with no transfer on either side
  localparam int MAX_REPORTS = 10;

  // one input item as the block sees it
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  opcode;
    logic [7:0]  mem_byte;
    logic [2:0]  reg_select;
    logic [15:0] write_value;
  } add_item_t;

  // architectural view after one item
  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  h;
    logic [7:0]  l;
    logic        z;
    logic        s;
    logic        p;
    logic        cy;
    logic        ac;
    logic [15:0] pc;
    logic        not_handled;
  } arch_view_t;

  // --------------------------------------------------------------------------
  // scoreboard: private copy of the processor state plus the pending views
  // --------------------------------------------------------------------------
  class add_group_scoreboard;
    logic [7:0]       regs[8];
    logic [15:0]      sp;
    logic [15:0]      pc;
    cag_pkg::flags_t  flg;
    arch_view_t       pending_views[$];
    int mismatches;
    int views_checked;
    int n_byte_adds, n_dad, n_daa, n_unhandled, n_writes;

    function new();
      foreach (regs[i]) regs[i] = 8'h00;
      sp  = 16'h0000;
      pc  = 16'h0000;
      flg = '0;
    endfunction

    function void set_zsp(logic [7:0] r);
      flg.z = (r == 8'h00);
      flg.s = r[7];
      flg.p = ~(^r);
    endfunction

    // 9-bit sum, carry in folded into the same add
    function void add_to_acc(logic [7:0] v, logic cin);
      logic [8:0] sum;
      logic [4:0] nib;
      sum = {1'b0, regs[cag_pkg::SEL_A]} + {1'b0, v} + {8'h00, cin};
      nib = {1'b0, regs[cag_pkg::SEL_A][3:0]} + {1'b0, v[3:0]} + {4'h0, cin};
      flg.cy = sum[8];
      flg.ac = nib[4];
      set_zsp(sum[7:0]);
      regs[cag_pkg::SEL_A] = sum[7:0];
      n_byte_adds++;
    endfunction

    function void add_to_hl(logic [15:0] pair);
      logic [16:0] sum;
      sum = {1'b0, regs[cag_pkg::SEL_H], regs[cag_pkg::SEL_L]} + {1'b0, pair};
      {regs[cag_pkg::SEL_H], regs[cag_pkg::SEL_L]} = sum[15:0];
      flg.cy = sum[16];
      n_dad++;
    endfunction

    // correction decided from the original accumulator and flags
    function void decimal_adjust();
      logic [7:0] corr;
      logic [3:0] lo, hi;
      logic [4:0] lo_sum;
      lo   = regs[cag_pkg::SEL_A][3:0];
      hi   = regs[cag_pkg::SEL_A][7:4];
      corr = 8'h00;
      if (flg.ac || lo > cag_pkg::BCD_MAX_DIGIT) corr[3:0] = cag_pkg::DAA_LO_CORR;
      if (flg.cy || hi > cag_pkg::BCD_MAX_DIGIT ||
          (hi >= cag_pkg::BCD_MAX_DIGIT && lo > cag_pkg::BCD_MAX_DIGIT)) begin
        corr[7:4] = cag_pkg::DAA_LO_CORR;
        flg.cy = 1'b1;
      end
      lo_sum = {1'b0, lo} + {1'b0, corr[3:0]};
      flg.ac = lo_sum[4];
      regs[cag_pkg::SEL_A] = regs[cag_pkg::SEL_A] + corr;
      set_zsp(regs[cag_pkg::SEL_A]);
      n_daa++;
    endfunction

    function logic [15:0] pair_value(logic [1:0] rp);
      case (rp)
        cag_pkg::RP_BC: return {regs[cag_pkg::SEL_B], regs[cag_pkg::SEL_C]};
        cag_pkg::RP_DE: return {regs[cag_pkg::SEL_D], regs[cag_pkg::SEL_E]};
        cag_pkg::RP_HL: return {regs[cag_pkg::SEL_H], regs[cag_pkg::SEL_L]};
        default:        return sp;
      endcase
    endfunction

    function arch_view_t execute_item(add_item_t it);
      logic [7:0]  operand;
      logic        handled;
      logic [15:0] pc_step;
      arch_view_t  v;
      handled = 1'b1;
      pc_step = 16'd1;
      case (it.kind)
        cag_pkg::KIND_WR_REG: begin
          if (it.reg_select == cag_pkg::SEL_FLAGS) begin
            flg.s  = it.write_value[cag_pkg::FB_S];
            flg.z  = it.write_value[cag_pkg::FB_Z];
            flg.ac = it.write_value[cag_pkg::FB_AC];
            flg.p  = it.write_value[cag_pkg::FB_P];
            flg.cy = it.write_value[cag_pkg::FB_CY];
          end else begin
            regs[it.reg_select] = it.write_value[7:0];
          end
          n_writes++;
        end
        cag_pkg::KIND_WR_SP: begin
          sp = it.write_value;
          n_writes++;
        end
        cag_pkg::KIND_WR_PC: begin
          pc = it.write_value;
          n_writes++;
        end
        default: begin
          operand = (it.opcode[2:0] == cag_pkg::SEL_FLAGS) ? it.mem_byte
                                                           : regs[it.opcode[2:0]];
          if (it.opcode[7:3] == cag_pkg::OPG_ADD) begin
            add_to_acc(operand, 1'b0);
          end else if (it.opcode[7:3] == cag_pkg::OPG_ADC) begin
            add_to_acc(operand, flg.cy);
          end else if (it.opcode == cag_pkg::OP_ADI) begin
            add_to_acc(it.mem_byte, 1'b0);
            pc_step = 16'd2;
          end else if (it.opcode == cag_pkg::OP_ACI) begin
            add_to_acc(it.mem_byte, flg.cy);
            pc_step = 16'd2;
          end else if (it.opcode[7:6] == 2'b00 && it.opcode[3:0] == cag_pkg::OPL_DAD) begin
            add_to_hl(pair_value(it.opcode[5:4]));
          end else if (it.opcode == cag_pkg::OP_DAA) begin
            decimal_adjust();
          end else begin
            handled = 1'b0;
            n_unhandled++;
          end
          if (handled) pc = pc + pc_step;
        end
      endcase
      v.acc         = regs[cag_pkg::SEL_A];
      v.h           = regs[cag_pkg::SEL_H];
      v.l           = regs[cag_pkg::SEL_L];
      v.z           = flg.z;
      v.s           = flg.s;
      v.p           = flg.p;
      v.cy          = flg.cy;
      v.ac          = flg.ac;
      v.pc          = pc;
      v.not_handled = ~handled;
      return v;
    endfunction

    function void note_transfer(add_item_t it);
      pending_views.push_back(execute_item(it));
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result %0d: %s expected %h got %h",
                   $realtime, views_checked, name, want, got);
      end
    endfunction

    function void check_result(arch_view_t got);
      arch_view_t want;
      if (pending_views.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result with nothing outstanding: %h", $realtime, got);
        return;
      end
      want = pending_views.pop_front();
      compare_field("acc_out", 16'(want.acc), 16'(got.acc));
      compare_field("h_out", 16'(want.h), 16'(got.h));
      compare_field("l_out", 16'(want.l), 16'(got.l));
      compare_field("zero_flag", 16'(want.z), 16'(got.z));
      compare_field("sign_flag", 16'(want.s), 16'(got.s));
      compare_field("parity_flag", 16'(want.p), 16'(got.p));
      compare_field("carry_flag", 16'(want.cy), 16'(got.cy));
      compare_field("aux_carry_flag", 16'(want.ac), 16'(got.ac));
      compare_field("pc_out", want.pc, got.pc);
      compare_field("not_handled", 16'(want.not_handled), 16'(got.not_handled));
      views_checked++;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and dut
  // --------------------------------------------------------------------------
  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic [1:0]  in_kind        = cag_pkg::KIND_WR_SP;
  logic [7:0]  in_opcode      = 8'h00;
  logic [7:0]  in_mem_byte    = 8'h00;
  logic [2:0]  in_reg_select  = cag_pkg::SEL_B;
  logic [15:0] in_write_value = 16'h0000;
  logic        out_stall      = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_acc_out;
  logic [7:0]  out_h_out;
  logic [7:0]  out_l_out;
  logic        out_zero_flag;
  logic        out_sign_flag;
  logic        out_parity_flag;
  logic        out_carry_flag;
  logic        out_aux_carry_flag;
  logic [15:0] out_pc_out;
  logic        out_not_handled;

  add_group_scoreboard sb = new();

  int items_sent;
  int burst_left;
  int idle_cycles;
  int in_blocked_cycles;  // cycles the block held back an offered item

  always #10 clk = ~clk;

  cpu_add_group_execute uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_opcode          (in_opcode),
    .in_mem_byte        (in_mem_byte),
    .in_reg_select      (in_reg_select),
    .in_write_value     (in_write_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_acc_out        (out_acc_out),
    .out_h_out          (out_h_out),
    .out_l_out          (out_l_out),
    .out_zero_flag      (out_zero_flag),
    .out_sign_flag      (out_sign_flag),
    .out_parity_flag    (out_parity_flag),
    .out_carry_flag     (out_carry_flag),
    .out_aux_carry_flag (out_aux_carry_flag),
    .out_pc_out         (out_pc_out),
    .out_not_handled    (out_not_handled)
  );

  // --------------------------------------------------------------------------
  // monitor: both channels sampled at the rising edge, before any nba lands
  // the result check runs first since a result always belongs to an older item
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    arch_view_t got;
    add_item_t  seen;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{acc: out_acc_out, h: out_h_out, l: out_l_out,
                z: out_zero_flag, s: out_sign_flag, p: out_parity_flag,
                cy: out_carry_flag, ac: out_aux_carry_flag,
                pc: out_pc_out, not_handled: out_not_handled};
        sb.check_result(got);
      end
      if (in_valid && !in_stall) begin
        seen = '{kind: in_kind, opcode: in_opcode, mem_byte: in_mem_byte,
                 reg_select: in_reg_select, write_value: in_write_value};
        sb.note_transfer(seen);
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: counts cycles with no transfer on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] no transfer for %0d cycles, %0d results outstanding",
                 $realtime, idle_cycles, sb.pending_views.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
    if (rst_n && in_valid && in_stall) in_blocked_cycles <= in_blocked_cycles + 1;
  end

  // --------------------------------------------------------------------------
  // result side: stall segments of random length, each in one of a few modes
  // the fourth segment is always a long hold so the block backs up and
  // stalls its input while the sender keeps offering items
  // --------------------------------------------------------------------------
  initial begin : receiver
    int seg_idx;
    int seg_len;
    int mode;
    int phase;
    seg_idx = 0;
    phase   = 0;
    forever begin
      if (seg_idx == 3 || $urandom_range(0, 14) == 0) begin
        mode    = 3;
        seg_len = $urandom_range(60, 150);
      end else begin
        mode    = $urandom_range(0, 2);
        seg_len = $urandom_range(20, 100);
      end
      repeat (seg_len) begin
        @(posedge clk);
        phase = (phase + 1) % 5;
        case (mode)
          0:       out_stall <= 1'b0;                        // drains freely
          1:       out_stall <= ($urandom_range(0, 9) < 4);  // random stalls
          2:       out_stall <= (phase < 2);                 // fixed 2-of-5 pattern
          default: out_stall <= 1'b1;                        // long hold
        endcase
      end
      seg_idx++;
    end
  end

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------

  // offer one item and wait for the edge where it transfers; at the end of a burst
  // valid then drops for a random gap before the task returns
  task automatic offer(input add_item_t it);
    in_valid       <= 1'b1;
    in_kind        <= it.kind;
    in_opcode      <= it.opcode;
    in_mem_byte    <= it.mem_byte;
    in_reg_select  <= it.reg_select;
    in_write_value <= it.write_value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // now and then a long unbroken burst
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                               : $urandom_range(0, 25);
    end else begin
      burst_left--;
    end
  endtask

  // execute an opcode; register select and write value carry noise
  task automatic run_op(input logic [7:0] op, input logic [7:0] mem);
    add_item_t it;
    it.kind        = cag_pkg::KIND_EXEC;
    it.opcode      = op;
    it.mem_byte    = mem;
    it.reg_select  = 3'($urandom);
    it.write_value = 16'($urandom);
    offer(it);
  endtask

  // register, flags, sp or pc write; opcode and memory byte carry noise
  task automatic write_state(input logic [1:0] kind, input logic [2:0] sel,
                             input logic [15:0] value);
    add_item_t it;
    it.kind        = kind;
    it.opcode      = 8'($urandom);
    it.mem_byte    = 8'($urandom);
    it.reg_select  = sel;
    it.write_value = value;
    offer(it);
  endtask

  function automatic logic [7:0] random_bcd();
    return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
  endfunction

  // one opcode from the add group, operands random
  function automatic logic [7:0] random_group_op();
    case ($urandom_range(0, 5))
      0:       return {cag_pkg::OPG_ADD, 3'($urandom)};
      1:       return {cag_pkg::OPG_ADC, 3'($urandom)};
      2:       return cag_pkg::OP_ADI;
      3:       return cag_pkg::OP_ACI;
      4:       return {2'b00, 2'($urandom), cag_pkg::OPL_DAD};
      default: return cag_pkg::OP_DAA;
    endcase
  endfunction

  initial begin : main
    int pick;
    items_sent        = 0;
    burst_left        = 0;
    idle_cycles       = 0;
    in_blocked_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed corner cases ----
    run_op({cag_pkg::OPG_ADD, cag_pkg::SEL_B}, 8'h5A);          // all-zero add from reset
    write_state(cag_pkg::KIND_WR_REG, cag_pkg::SEL_A, 16'hABFF); // upper byte must be dropped
    write_state(cag_pkg::KIND_WR_REG, cag_pkg::SEL_B, 16'h0001);
    run_op({cag_pkg::OPG_ADD, cag_pkg::SEL_B}, 8'h00);          // ff + 01: zero, carry, aux
    write_state(cag_pkg::KIND_WR_REG, cag_pkg::SEL_FLAGS, 16'hFFFF);  // every flag set
    write_state(cag_pkg::KIND_WR_REG, cag_pkg::SEL_C, 16'h00FF);
    run_op({cag_pkg::OPG_ADC, cag_pkg::SEL_C}, 8'h00);          // carry in, one 9-bit sum
    run_op({cag_pkg::OPG_ADC, cag_pkg::SEL_FLAGS}, 8'hFF);      // adc from memory byte
    run_op({cag_pkg::OPG_ADD, cag_pkg::SEL_A}, 8'h33);          // a + a
    run_op(cag_pkg::OP_ADI, 8'h80);
    run_op(cag_pkg::OP_ACI, 8'hFF);
    write_state(cag_pkg::KIND_WR_PC, cag_pkg::SEL_B, 16'hFFFF);
    run_op(cag_pkg::OP_ADI, 8'h7F);                             // pc wraps past ffff by two
    write_state(cag_pkg::KIND_WR_SP, cag_pkg::SEL_B, 16'hFFFF);
    write_state(cag_pkg::KIND_WR_REG, cag_pkg::SEL_H, 16'h00FF);
    write_state(cag_pkg::KIND_WR_REG, cag_pkg::SEL_L, 16'h00FF);
    run_op({2'b00, cag_pkg::RP_SP, cag_pkg::OPL_DAD}, 8'h00);   // 16-bit carry out
    write_state(cag_pkg::KIND_WR_REG, cag_pkg::SEL_D, 16'h0080);
    run_op({2'b00, cag_pkg::RP_DE, cag_pkg::OPL_DAD}, 8'h00);
    run_op({2'b00, cag_pkg::RP_BC, cag_pkg::OPL_DAD}, 8'h00);
    run_op({2'b00, cag_pkg::RP_HL, cag_pkg::OPL_DAD}, 8'h00);   // hl doubled
    write_state(cag_pkg::KIND_WR_REG, cag_pkg::SEL_FLAGS, 16'h0000);
    write_state(cag_pkg::KIND_WR_REG, cag_pkg::SEL_A, 16'h009A);
    run_op(cag_pkg::OP_DAA, 8'h00);                             // high nibble 9, low above 9
    write_state(cag_pkg::KIND_WR_REG, cag_pkg::SEL_FLAGS, 16'h0010);  // aux carry only
    write_state(cag_pkg::KIND_WR_REG, cag_pkg::SEL_A, 16'h0099);
    run_op(cag_pkg::OP_DAA, 8'h00);
    write_state(cag_pkg::KIND_WR_REG, cag_pkg::SEL_FLAGS, 16'h0001);  // carry only
    write_state(cag_pkg::KIND_WR_REG, cag_pkg::SEL_A, 16'h0000);
    run_op(cag_pkg::OP_DAA, 8'h00);
    run_op(8'h00, 8'hFF);                                       // not in the group
    run_op(8'hFF, 8'h00);

    // ---- random traffic ----
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        run_op(random_group_op(), 8'($urandom));
      end else if (pick < 52) begin
        // decimal add sequence: bcd accumulator, bcd add, adjust
        write_state(cag_pkg::KIND_WR_REG, cag_pkg::SEL_A, {8'($urandom), random_bcd()});
        if ($urandom_range(0, 3) == 0)
          write_state(cag_pkg::KIND_WR_REG, cag_pkg::SEL_FLAGS, 16'($urandom));
        if ($urandom_range(0, 1) == 0) begin
          run_op($urandom_range(0, 1) ? cag_pkg::OP_ADI : cag_pkg::OP_ACI, random_bcd());
        end else begin
          write_state(cag_pkg::KIND_WR_REG, cag_pkg::SEL_B, {8'($urandom), random_bcd()});
          run_op({$urandom_range(0, 1) ? cag_pkg::OPG_ADD : cag_pkg::OPG_ADC, cag_pkg::SEL_B},
                 8'($urandom));
        end
        run_op(cag_pkg::OP_DAA, 8'($urandom));
      end else if (pick < 60) begin
        run_op(8'($urandom), 8'($urandom));           // any opcode at all
      end else if (pick < 85) begin
        write_state(cag_pkg::KIND_WR_REG, 3'($urandom), 16'($urandom));
      end else if (pick < 92) begin
        write_state(cag_pkg::KIND_WR_SP, 3'($urandom),
                    $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom));
      end else begin
        write_state(cag_pkg::KIND_WR_PC, 3'($urandom),
                    $urandom_range(0, 2) == 0 ? 16'($urandom_range(16'hFFFD, 16'hFFFF))
                                              : 16'($urandom));
      end
    end

    // ---- drain and report ----
    in_valid <= 1'b0;
    while (sb.pending_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("covered %0d items: %0d byte adds, %0d dad, %0d daa, %0d unhandled, %0d writes",
             items_sent, sb.n_byte_adds, sb.n_dad, sb.n_daa, sb.n_unhandled, sb.n_writes);
    $display("%0d results checked, input held back %0d cycles, %0d mismatches",
             sb.views_checked, in_blocked_cycles, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_views.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
